FILE: sv/kxh_pkg.sv
// ----------------------------------------------------------------------------
// kxh_pkg
// Shared types and constants for the key exchange handshake engine.
// ----------------------------------------------------------------------------
package kxh_pkg;

    // Wait timer width and the width used to compare it against the limit
    localparam int TIMER_WIDTH = 16;
    localparam int TMO_WIDTH   = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > TMO_WIDTH) ? TIMER_WIDTH : TMO_WIDTH;

    // Link characters
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_A = 8'h41;

    // Configuration reset values
    localparam logic [TMO_WIDTH-1:0] TIMEOUT_RESET = TMO_WIDTH'(1000);

    // Most bytes sent in reply to one item
    localparam int MAX_TX = 5;
    localparam int CNT_W  = $clog2(MAX_TX + 1);

    // Configuration register indexes (byte address = 4 * index)
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_ROLE    = 2'd0,
        REG_OWN_KEY = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_idx_t;

    // Handshake phases
    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_ACKWAIT  = 4'd1,
        PH_EXCH_C   = 4'd2,
        PH_LISTEN   = 4'd3,
        PH_KEYWAIT1 = 4'd4,
        PH_ACKWAIT1 = 4'd5,
        PH_KEYWAIT2 = 4'd6,
        PH_ACKWAIT2 = 4'd7,
        PH_EXCH_S   = 4'd8
    } phase_t;

    // Everything one item produces: up to MAX_TX bytes plus status
    typedef struct packed {
        logic                        tx_any;
        logic [CNT_W-1:0]            count;
        logic [MAX_TX-1:0][7:0]      bytes;
        logic                        done;
        logic [31:0]                 partner;
        phase_t                      phase;
    } burst_t;

endpackage

FILE: sv/kxh_stream_if.sv
// ----------------------------------------------------------------------------
// kxh_stream_if
// Valid/ready channels for the handshake engine: item input and beat output.
// ----------------------------------------------------------------------------
interface kxh_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface kxh_out_if
    import kxh_pkg::*;
    ;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        done_res;
    logic [31:0] partner_key;
    phase_t      phase;

    modport source (output valid, output tx_valid, output tx_byte, output last,
                    output done_res, output partner_key, output phase, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input last,
                    input done_res, input partner_key, input phase, output ready);
endinterface

FILE: sv/kxh_core.sv
// ----------------------------------------------------------------------------
// kxh_core
// Handshake state and the combinational decision for one tick or byte.
// ----------------------------------------------------------------------------
module kxh_core
    import kxh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  operation,
    input  logic [7:0]            rx_byte,
    input  logic                  role_we,
    input  logic                  role_value,
    input  logic [31:0]           own_key,
    input  logic [TMO_WIDTH-1:0]  timeout_ticks,
    output burst_t                burst
);

    phase_t                   phase_reg,  phase_next;
    logic [2:0]               count_reg,  count_next;
    logic [7:0]               first_reg,  first_next;
    logic [31:0]              shift_reg,  shift_next;
    logic [TIMER_WIDTH-1:0]   timer_reg,  timer_next;
    logic [31:0]              partner_reg, partner_next;

    logic                     in_wait;
    logic [TIMER_WIDTH-1:0]   timer_inc;
    logic                     timeout_hit;
    logic [31:0]              shift_in;
    logic [2:0]               count_inc;
    logic                     enter;
    phase_t                   enter_phase;

    // Timer and key shift helpers
    assign in_wait = (phase_reg == PH_ACKWAIT)  || (phase_reg == PH_KEYWAIT1) ||
                     (phase_reg == PH_ACKWAIT1) || (phase_reg == PH_KEYWAIT2) ||
                     (phase_reg == PH_ACKWAIT2);
    assign timer_inc   = (timer_reg == '1) ? timer_reg : timer_reg + 1'b1;
    assign timeout_hit = CMP_WIDTH'(timer_inc) >= CMP_WIDTH'(timeout_ticks);
    assign shift_in    = {rx_byte, shift_reg[31:8]};
    assign count_inc   = count_reg + 3'd1;

    // Next state and reply bytes for the item at the input
    always_comb
    begin
        count_next   = count_reg;
        first_next   = first_reg;
        shift_next   = shift_reg;
        timer_next   = timer_reg;
        partner_next = partner_reg;
        enter        = 1'b0;
        enter_phase  = phase_reg;
        burst.tx_any = 1'b0;
        burst.count  = CNT_W'(1);
        burst.bytes  = '0;

        if (phase_reg == PH_START)
        begin
            // Any item starts the client send
            burst.tx_any = 1'b1;
            burst.count  = CNT_W'(MAX_TX);
            burst.bytes  = {own_key, CH_C};
            enter        = 1'b1;
            enter_phase  = PH_ACKWAIT;
        end
        else if (!operation)
        begin
            // Tick: only wait states count
            if (in_wait)
            begin
                timer_next = timer_inc;
                if (timeout_hit)
                begin
                    enter = 1'b1;
                    if (phase_reg == PH_ACKWAIT)
                    begin
                        burst.tx_any = 1'b1;
                        burst.count  = CNT_W'(MAX_TX);
                        burst.bytes  = {own_key, CH_C};
                        enter_phase  = PH_ACKWAIT;
                    end
                    else
                    begin
                        enter_phase = PH_LISTEN;
                    end
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_ACKWAIT:
                begin
                    if (count_reg == 3'd0)
                    begin
                        first_next = rx_byte;
                        count_next = 3'd1;
                    end
                    else
                    begin
                        shift_next = shift_in;
                        count_next = count_inc;
                        // Fifth byte closes the response
                        if (count_reg == 3'd4)
                        begin
                            enter        = 1'b1;
                            burst.tx_any = 1'b1;
                            if (first_reg == CH_A)
                            begin
                                partner_next = shift_in;
                                burst.count  = CNT_W'(1);
                                burst.bytes  = {32'd0, CH_A};
                                enter_phase  = PH_EXCH_C;
                            end
                            else
                            begin
                                burst.count = CNT_W'(MAX_TX);
                                burst.bytes = {own_key, CH_C};
                                enter_phase = PH_ACKWAIT;
                            end
                        end
                    end
                end
                PH_LISTEN:
                begin
                    if (rx_byte == CH_C)
                    begin
                        enter       = 1'b1;
                        enter_phase = PH_KEYWAIT1;
                    end
                end
                PH_KEYWAIT1, PH_KEYWAIT2:
                begin
                    shift_next = shift_in;
                    count_next = count_inc;
                    if (count_reg == 3'd3)
                    begin
                        partner_next = shift_in;
                        enter        = 1'b1;
                        if (phase_reg == PH_KEYWAIT1)
                        begin
                            burst.tx_any = 1'b1;
                            burst.count  = CNT_W'(MAX_TX);
                            burst.bytes  = {own_key, CH_A};
                            enter_phase  = PH_ACKWAIT1;
                        end
                        else
                        begin
                            enter_phase = PH_ACKWAIT2;
                        end
                    end
                end
                PH_ACKWAIT1, PH_ACKWAIT2:
                begin
                    if (rx_byte == CH_A)
                    begin
                        enter       = 1'b1;
                        enter_phase = PH_EXCH_S;
                    end
                    else if (rx_byte == CH_C)
                    begin
                        enter       = 1'b1;
                        enter_phase = PH_KEYWAIT2;
                    end
                    else
                    begin
                        timer_next = '0;
                    end
                end
                default:
                begin
                    // Exchange reached or unused code: byte ignored
                end
            endcase
        end

        // Entering a phase clears the per-phase counters
        phase_next = enter_phase;
        if (enter)
        begin
            count_next = '0;
            first_next = '0;
            shift_next = '0;
            timer_next = '0;
        end

        burst.done    = (phase_next == PH_EXCH_C) || (phase_next == PH_EXCH_S);
        burst.partner = partner_next;
        burst.phase   = phase_next;
    end

    // State registers; a role write restarts the handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            count_reg   <= '0;
            first_reg   <= '0;
            shift_reg   <= '0;
            timer_reg   <= '0;
            partner_reg <= '0;
        end
        else if (role_we)
        begin
            phase_reg <= role_value ? PH_LISTEN : PH_START;
            count_reg <= '0;
            first_reg <= '0;
            shift_reg <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            shift_reg   <= shift_next;
            timer_reg   <= timer_next;
            partner_reg <= partner_next;
        end
    end

    // Timer only runs in wait states
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_wait |-> timer_reg == '0)
        else $error("wait timer nonzero outside a wait state");

    // A full key never stays buffered
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("byte count past four");

    // Key bytes only collect in key-collecting phases
    a_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 3'd0) |-> (phase_reg == PH_ACKWAIT || phase_reg == PH_KEYWAIT1 ||
                                 phase_reg == PH_KEYWAIT2))
        else $error("byte count held in a phase that collects none");

endmodule

FILE: sv/key_exchange_handshake.sv
// ----------------------------------------------------------------------------
// key_exchange_handshake
// Key swap engine over a byte link: APB config, item input, beat output.
// ----------------------------------------------------------------------------
// The first beat of an item's reply is valid in the cycle after accept.
// Throughput: one item per cycle when it yields one beat and the output is
//   ready; a key-sending item gives five beats, one per ready cycle, and the
//   next item enters in the cycle its last beat leaves (single reply buffer).
// Reset: rst_n clears to client role, start phase, partner key zero,
//   own key zero and timeout 1000 ticks; no reply is pending.
module key_exchange_handshake
    import kxh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    kxh_in_if.sink              in_ch,
    kxh_out_if.source           out_ch
);

    logic                  role_reg;
    logic [31:0]           own_key_reg;
    logic [TMO_WIDTH-1:0]  timeout_reg;
    logic                  cfg_we;
    reg_idx_t              cfg_idx;
    logic                  role_we;

    burst_t                burst_now;
    burst_t                burst_reg;
    logic                  pend_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic                  final_beat;
    logic                  accept;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign role_we = cfg_we && (cfg_idx == REG_ROLE);

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROLE:    prdata = {31'd0, role_reg};
            REG_OWN_KEY: prdata = own_key_reg;
            REG_TIMEOUT: prdata = 32'(timeout_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg    <= 1'b0;
            own_key_reg <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ROLE:    role_reg    <= pwdata[0];
                REG_OWN_KEY: own_key_reg <= pwdata;
                REG_TIMEOUT: timeout_reg <= pwdata[TMO_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // Decision logic and handshake state
    kxh_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .operation     (in_ch.operation),
        .rx_byte       (in_ch.rx_byte),
        .role_we       (role_we),
        .role_value    (pwdata[0]),
        .own_key       (own_key_reg),
        .timeout_ticks (timeout_reg),
        .burst         (burst_now)
    );

    // Input is taken when the reply buffer is empty or drains this cycle
    assign final_beat = out_ch.ready && (rem_reg == CNT_W'(1));
    assign in_ch.ready = !pend_reg || final_beat;
    assign accept      = in_ch.valid && in_ch.ready;

    // Reply buffer: one beat per cycle while out_ch.ready is high, bytes shift down
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (accept)
        begin
            pend_reg <= 1'b1;
            rem_reg  <= burst_now.count;
        end
        else if (pend_reg && out_ch.ready)
        begin
            pend_reg <= (rem_reg != CNT_W'(1));
            rem_reg  <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            burst_reg <= burst_now;
        end
        else if (pend_reg && out_ch.ready)
        begin
            burst_reg.bytes <= burst_reg.bytes >> 8;
        end
    end

    // Beat outputs
    assign out_ch.valid       = pend_reg;
    assign out_ch.tx_valid    = burst_reg.tx_any;
    assign out_ch.tx_byte     = burst_reg.tx_any ? burst_reg.bytes[0] : 8'd0;
    assign out_ch.last        = (rem_reg == CNT_W'(1));
    assign out_ch.done_res    = burst_reg.done;
    assign out_ch.partner_key = burst_reg.partner;
    assign out_ch.phase       = burst_reg.phase;

    // A reply with nothing to send is a single beat
    a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !burst_reg.tx_any) |-> (rem_reg == CNT_W'(1)))
        else $error("empty reply spans more than one beat");

    // Pending count stays within the reply size
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (rem_reg != '0 && rem_reg <= CNT_W'(MAX_TX)))
        else $error("beat count out of range");

    // No new item while an unfinished reply blocks the buffer
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !final_beat) |-> !in_ch.ready)
        else $error("item taken over a pending reply");

    // Done flag follows the reported phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (burst_reg.done ==
                      (burst_reg.phase == PH_EXCH_C || burst_reg.phase == PH_EXCH_S)))
        else $error("done flag disagrees with phase");

endmodule
